// File: src/fci_pkg.sv
// ----------------------------------------------------------------------------
// fci_pkg
// shared constants, register codes, status type and duty helper for the
// fan curve interpolation unit
// ----------------------------------------------------------------------------
package fci_pkg;

   // default parameter values
   localparam int MAX_POINTS_DEF     = 6;
   localparam int TEMP_FRAC_BITS_DEF = 8;

   // field widths
   localparam int TEMP_W     = 16;
   localparam int DUTY_W     = 15;
   localparam int PCT_W      = 7;
   localparam int PCT_FRAC_W = 8;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int COUNT_W    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_0     = 3'd1;

   // reset values
   localparam logic [COUNT_W-1:0] COUNT_RESET   = 3'd2;
   localparam logic [CSR_W-1:0]   POINT_0_RESET = 16'd7680;
   localparam logic [CSR_W-1:0]   POINT_1_RESET = 16'd18020;

   // duty limits
   localparam logic [7:0]        PCT_MAX  = 8'd100;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 15'd25600;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // duty byte saturated to full scale
   function automatic logic [PCT_W-1:0] sat_pct(input logic [7:0] pct);
      logic [PCT_W-1:0] res;
      if (pct > PCT_MAX) begin
         res = PCT_MAX[PCT_W-1:0];
      end else begin
         res = pct[PCT_W-1:0];
      end
      return res;
   endfunction

endpackage

// File: src/fci_mul.sv
// ----------------------------------------------------------------------------
// fci_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module fci_mul #(
   parameter int OW = 16,
   parameter int MW = fci_pkg::PCT_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OW-1:0]            operand,
   input  logic [MW-1:0]            multiplier,
   output logic [OW-1:0]            product_hi,
   output logic [MW-1:0]            product_lo,
   output fci_pkg::unit_status_type status
);

   localparam int CNT_W = $clog2(MW + 1);

   logic [OW-1:0]    op_ff;
   logic [OW-1:0]    hi_ff;
   logic [MW-1:0]    lo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [OW:0]      sum;

   // add the operand when the current multiplier bit is set
   assign sum = lo_ff[0] ? ({1'b0, hi_ff} + {1'b0, op_ff}) : {1'b0, hi_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(MW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         op_ff <= operand;
         hi_ff <= '0;
         lo_ff <= multiplier;
      end else if (busy_ff) begin
         hi_ff <= sum[OW:1];
         lo_ff <= {sum[0], lo_ff[MW-1:1]};
      end
   end

   assign product_hi  = hi_ff;
   assign product_lo  = lo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: src/fci_div.sv
// ----------------------------------------------------------------------------
// fci_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fci_div #(
   parameter int DW = 16,
   parameter int QW = fci_pkg::DUTY_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DW-1:0]            rem_init,
   input  logic [QW-1:0]            low_bits,
   input  logic [DW-1:0]            divisor,
   output logic [QW-1:0]            quotient,
   output fci_pkg::unit_status_type status
);

   localparam int CNT_W = $clog2(QW + 1);

   logic [DW-1:0]    rem_ff;
   logic [QW-1:0]    sh_ff;
   logic [DW-1:0]    dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DW:0]      cur;
   logic [DW+1:0]    diff;
   logic             q_bit;

   // remainder stays below the divisor, so the trial fits one bit wider
   assign cur   = {rem_ff, sh_ff[QW-1]};
   assign diff  = {1'b0, cur} - {2'b00, dsr_ff};
   assign q_bit = ~diff[DW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff <= rem_init;
         sh_ff  <= low_bits;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= q_bit ? diff[DW-1:0] : cur[DW-1:0];
         sh_ff  <= {sh_ff[QW-2:0], q_bit};
      end
   end

   assign quotient    = sh_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: src/fan_curve_interpolation_unit.sv
// ----------------------------------------------------------------------------
// fan_curve_interpolation_unit
// maps a temperature sample to a fan duty through a piecewise-linear curve
// ----------------------------------------------------------------------------
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ------------------------------
//  request   req_temperature                     start && !busy
//  response  rsp_duty, rsp_below_curve           rsp_valid, one cycle strobe
//  csr       csr_index, csr_wdata                csr_we, no wait, no read-back
//
//  sequence: walks 1 to MAX_POINTS-1 segments, then for an interpolated point
//  multiply start, multiply, hand-over, divide, finish; the result strobe
//  rises in the same cycle as busy falls
//  reset: synchronous, restores the default two-point curve
//  stalls: the receiver cannot stall; a new beat is taken while the previous
//  result is on the response ports
//
module fan_curve_interpolation_unit #(
   parameter int MAX_POINTS     = fci_pkg::MAX_POINTS_DEF,
   parameter int TEMP_FRAC_BITS = fci_pkg::TEMP_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [fci_pkg::TEMP_W-1:0]     req_temperature,
   // response
   output logic                                  rsp_valid,
   output logic        [fci_pkg::DUTY_W-1:0]     rsp_duty,
   output logic                                  rsp_below_curve,
   // configuration
   input  logic                                  csr_we,
   input  logic        [fci_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [fci_pkg::CSR_W-1:0]      csr_wdata
);

   // point temperature width, compare width, segment counter width
   localparam int PW = 8 + TEMP_FRAC_BITS;
   localparam int CW = ((PW > fci_pkg::TEMP_W) ? PW : fci_pkg::TEMP_W) + 1;
   localparam int SW = $clog2(MAX_POINTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_MUL,
      ST_DIV
   } state_type;

   // configuration registers
   logic [fci_pkg::COUNT_W-1:0] point_count_ff;
   logic [fci_pkg::CSR_W-1:0]   point_ff [MAX_POINTS];

   // walk and result registers
   state_type                         state_ff, state_in;
   logic [fci_pkg::CSR_W-1:0]         work_ff [MAX_POINTS];
   logic [fci_pkg::CSR_W-1:0]         work_in [MAX_POINTS];
   logic [SW-1:0]                     seg_ff, seg_in;
   logic signed [fci_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic [PW-1:0]                     off_ff, off_in;
   logic [PW-1:0]                     dsr_ff, dsr_in;
   logic [fci_pkg::PCT_W-1:0]         base_ff, base_in;
   logic [fci_pkg::PCT_W-1:0]         mag_ff, mag_in;
   logic                              neg_ff, neg_in;
   logic                              mul_start_ff, mul_start_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [fci_pkg::DUTY_W-1:0]        rsp_duty_ff, rsp_duty_in;
   logic                              rsp_below_ff, rsp_below_in;

   // segment decode
   logic [fci_pkg::COUNT_W-1:0] n_clamped;
   logic [SW-1:0]               seg_init;
   logic signed [CW-1:0]        temp_w;
   logic signed [CW-1:0]        t0_w;
   logic signed [CW-1:0]        t1_w;
   logic [CW-1:0]               off_full;
   logic [CW-1:0]               dsr_full;
   logic [fci_pkg::PCT_W-1:0]   p0;
   logic [fci_pkg::PCT_W-1:0]   p1;
   logic [fci_pkg::DUTY_W-1:0]  d0;

   // serial arithmetic
   fci_pkg::unit_status_type    mul_status;
   fci_pkg::unit_status_type    div_status;
   logic [PW-1:0]               mul_hi;
   logic [fci_pkg::PCT_W-1:0]   mul_lo;
   logic [fci_pkg::DUTY_W-1:0]  quo;

   // ---------------------------------------------------------------------
   // configuration registers; points beyond MAX_POINTS are never read
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= fci_pkg::COUNT_RESET;
         for (int j = 0; j < MAX_POINTS; j++) begin
            point_ff[j] <= '0;
         end
         point_ff[0] <= fci_pkg::POINT_0_RESET;
         point_ff[1] <= fci_pkg::POINT_1_RESET;
      end else if (csr_we) begin
         if (csr_index == fci_pkg::CSR_POINT_COUNT) begin
            point_count_ff <= csr_wdata[fci_pkg::COUNT_W-1:0];
         end
         for (int j = 0; j < MAX_POINTS; j++) begin
            if (csr_index == fci_pkg::CSR_POINT_0 + fci_pkg::CSR_IDX_W'(j)) begin
               point_ff[j] <= csr_wdata;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // point count clamped to the usable range, segments to walk
   // ---------------------------------------------------------------------
   always_comb begin
      if (point_count_ff < fci_pkg::COUNT_W'(2)) begin
         n_clamped = fci_pkg::COUNT_W'(2);
      end else if (point_count_ff > fci_pkg::COUNT_W'(MAX_POINTS)) begin
         n_clamped = fci_pkg::COUNT_W'(MAX_POINTS);
      end else begin
         n_clamped = point_count_ff;
      end
   end

   assign seg_init = SW'(n_clamped - fci_pkg::COUNT_W'(1));

   // ---------------------------------------------------------------------
   // current segment: start point in work tap 0, end point in work tap 1
   // ---------------------------------------------------------------------
   assign temp_w = {{(CW-fci_pkg::TEMP_W){temp_ff[fci_pkg::TEMP_W-1]}}, temp_ff};
   assign t0_w   = {{(CW-8){work_ff[0][15]}}, work_ff[0][15:8]} << TEMP_FRAC_BITS;
   assign t1_w   = {{(CW-8){work_ff[1][15]}}, work_ff[1][15:8]} << TEMP_FRAC_BITS;

   // inside a segment the offset and span are both non-negative and below 2^PW
   assign off_full = temp_w - t0_w;
   assign dsr_full = t1_w - t0_w;

   assign p0 = fci_pkg::sat_pct(work_ff[0][7:0]);
   assign p1 = fci_pkg::sat_pct(work_ff[1][7:0]);
   assign d0 = {base_ff, {fci_pkg::PCT_FRAC_W{1'b0}}};

   // ---------------------------------------------------------------------
   // sequencer: walk, multiply, divide, emit
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      seg_in       = seg_ff;
      temp_in      = temp_ff;
      off_in       = off_ff;
      dsr_in       = dsr_ff;
      base_in      = base_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mul_start_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_duty_in  = rsp_duty_ff;
      rsp_below_in = rsp_below_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               work_in  = point_ff;
               seg_in   = seg_init;
               temp_in  = req_temperature;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (t0_w > temp_w) begin
               // segment start above the sample
               rsp_valid_in = 1'b1;
               rsp_duty_in  = '0;
               rsp_below_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (t1_w > temp_w) begin
               // sample inside this segment
               off_in       = off_full[PW-1:0];
               dsr_in       = dsr_full[PW-1:0];
               base_in      = p0;
               neg_in       = (p1 < p0);
               mag_in       = (p1 < p0) ? (p0 - p1) : (p1 - p0);
               mul_start_in = 1'b1;
               state_in     = ST_MUL;
            end else if (seg_ff == SW'(1)) begin
               // past the last point
               rsp_valid_in = 1'b1;
               rsp_duty_in  = {p1, {fci_pkg::PCT_FRAC_W{1'b0}}};
               rsp_below_in = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               for (int j = 0; j < MAX_POINTS - 1; j++) begin
                  work_in[j] = work_ff[j+1];
               end
               seg_in = seg_ff - SW'(1);
            end
         end
         ST_MUL: begin
            if (mul_status.done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = neg_ff ? (d0 - quo) : (d0 + quo);
               rsp_below_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff      <= work_in;
      seg_ff       <= seg_in;
      temp_ff      <= temp_in;
      off_ff       <= off_in;
      dsr_ff       <= dsr_in;
      base_ff      <= base_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_below_ff <= rsp_below_in;
   end

   // ---------------------------------------------------------------------
   // offset times duty step, shifted up by the duty fraction and divided by
   // the segment span; the quotient is below 2^15 so the upper product bits
   // already sit below the divisor
   // ---------------------------------------------------------------------
   fci_mul #(
      .OW (PW),
      .MW (fci_pkg::PCT_W)
   ) u_mul (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start_ff),
      .operand    (off_ff),
      .multiplier (mag_ff),
      .product_hi (mul_hi),
      .product_lo (mul_lo),
      .status     (mul_status)
   );

   fci_div #(
      .DW (PW),
      .QW (fci_pkg::DUTY_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_status.done),
      .rem_init (mul_hi),
      .low_bits ({mul_lo, {fci_pkg::PCT_FRAC_W{1'b0}}}),
      .divisor  (dsr_ff),
      .quotient (quo),
      .status   (div_status)
   );

   // outputs
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty        = rsp_duty_ff;
   assign rsp_below_curve = rsp_below_ff;

`ifndef NO_ASSERTIONS
   // a result strobe is never high on consecutive clock edges
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // below the curve the duty is zero
   a_below_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_below_curve) |-> (rsp_duty == '0))
      else $error("non-zero duty below the curve");

   // duty within full scale
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty <= fci_pkg::DUTY_MAX))
      else $error("duty above full scale");

   // an accepted beat makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // multiplier and divider never run together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_status.busy && div_status.busy))
      else $error("multiplier and divider busy together");
`endif

endmodule

// File: tb/fan_curve_interpolation_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fan_curve_interpolation_unit_tb
// self-checking bench for the fan curve unit: a table of directed samples and
// curve writes, then random curves with random samples, every duty beat
// compared against a directed value or a cycle-free model of the segment walk
// ----------------------------------------------------------------------------
module fan_curve_interpolation_unit_tb;

   localparam int             NUM_POINTS      = fci_pkg::MAX_POINTS_DEF;
   localparam logic [fci_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int             NUM_PHASES      = 12;
   localparam int             BEATS_PER_PHASE = 150;
   localparam int             PLAN_LEN        = 34;
   localparam int             TAIL_CYCLES     = 40;

   // one duty beat as seen on the response ports
   typedef struct packed {
      logic [fci_pkg::DUTY_W-1:0] duty;
      logic                       below;
   } duty_beat_type;

   // one row of the directed plan: either a register write or a sample
   typedef struct packed {
      logic                              is_csr;
      logic [fci_pkg::CSR_IDX_W-1:0]     idx;
      logic [fci_pkg::CSR_W-1:0]         wdata;
      logic signed [fci_pkg::TEMP_W-1:0] temp;
      logic                              known;
      logic [fci_pkg::DUTY_W-1:0]        duty;
      logic                              below;
   } plan_row_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic signed [fci_pkg::TEMP_W-1:0] req_temperature;
   logic                              rsp_valid;
   logic [fci_pkg::DUTY_W-1:0]        rsp_duty;
   logic                              rsp_below_curve;
   logic                              csr_we;
   logic [fci_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [fci_pkg::CSR_W-1:0]         csr_wdata;

   // bench copy of the curve registers
   logic [fci_pkg::COUNT_W-1:0] cfg_count;
   logic [fci_pkg::CSR_W-1:0]   cfg_point [NUM_POINTS];

   duty_beat_type pending_duty [$];
   plan_row_type  plan [PLAN_LEN];

   int beats_sent;
   int results_seen;
   int below_seen;
   int full_seen;
   int curves_loaded;
   int mismatches;

   fan_curve_interpolation_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_temperature (req_temperature),
      .rsp_valid       (rsp_valid),
      .rsp_duty        (rsp_duty),
      .rsp_below_curve (rsp_below_curve),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // safety net: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // curve model
   // ---------------------------------------------------------------------------

   // point temperature in the sample's fixed-point format
   function automatic longint point_temp(input logic [fci_pkg::CSR_W-1:0] word);
      logic signed [7:0] deg;
      deg = word[15:8];
      return longint'(deg) * (longint'(1) << fci_pkg::TEMP_FRAC_BITS_DEF);
   endfunction

   // point duty in Q7.8 percent, byte capped at full scale
   function automatic longint point_duty(input logic [fci_pkg::CSR_W-1:0] word);
      logic [7:0] pct;
      pct = word[7:0];
      if (pct > fci_pkg::PCT_MAX) begin
         pct = fci_pkg::PCT_MAX;
      end
      return longint'(pct) * (longint'(1) << fci_pkg::PCT_FRAC_W);
   endfunction

   // walk the segments in order, as the hardware does
   function automatic duty_beat_type curve_duty(
      input logic signed [fci_pkg::TEMP_W-1:0] temp);
      duty_beat_type res;
      int            n;
      int            seg;
      int            base;
      bit            settled;
      longint        t;
      longint        t0;
      longint        t1;
      longint        d0;
      longint        d1;
      longint        duty;
      t = longint'(temp);
      n = int'(cfg_count);
      // count outside 2..MAX_POINTS is pulled back into range
      if (n < 2) begin
         n = 2;
      end
      if (n > NUM_POINTS) begin
         n = NUM_POINTS;
      end
      res.below = 1'b0;
      duty      = 0;
      base      = 0;
      settled   = 1'b0;
      for (seg = 1; seg < n && !settled; seg++) begin
         t0 = point_temp(cfg_point[base]);
         t1 = point_temp(cfg_point[seg]);
         if (t0 > t) begin
            res.below = 1'b1;
            duty      = 0;
            settled   = 1'b1;
         end else if (t1 > t) begin
            d0      = point_duty(cfg_point[base]);
            d1      = point_duty(cfg_point[seg]);
            // signed divide truncates toward zero, also on falling segments
            duty    = d0 + ((t - t0) * (d1 - d0)) / (t1 - t0);
            settled = 1'b1;
         end else begin
            if (seg == n - 1) begin
               duty = point_duty(cfg_point[seg]);
            end
            base = seg;
         end
      end
      if (duty < 0) begin
         duty = 0;
      end
      if (duty > longint'(fci_pkg::DUTY_MAX)) begin
         duty = longint'(fci_pkg::DUTY_MAX);
      end
      res.duty = duty[fci_pkg::DUTY_W-1:0];
      return res;
   endfunction

   // mirror of the register file; unmapped indexes are dropped
   function automatic void apply_csr(input logic [fci_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [fci_pkg::CSR_W-1:0] value);
      if (idx == fci_pkg::CSR_POINT_COUNT) begin
         cfg_count = value[fci_pkg::COUNT_W-1:0];
      end else if (idx >= fci_pkg::CSR_POINT_0 &&
                   int'(idx - fci_pkg::CSR_POINT_0) < NUM_POINTS) begin
         cfg_point[idx - fci_pkg::CSR_POINT_0] = value;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // directed plan rows
   // ---------------------------------------------------------------------------

   function automatic plan_row_type csr_row(input logic [fci_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [fci_pkg::CSR_W-1:0] value);
      plan_row_type row;
      row        = '0;
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.wdata  = value;
      return row;
   endfunction

   function automatic plan_row_type sample_row(
      input logic signed [fci_pkg::TEMP_W-1:0] temp);
      plan_row_type row;
      row      = '0;
      row.temp = temp;
      return row;
   endfunction

   function automatic plan_row_type known_row(
      input logic signed [fci_pkg::TEMP_W-1:0] temp,
      input logic [fci_pkg::DUTY_W-1:0] duty,
      input logic below);
      plan_row_type row;
      row       = '0;
      row.temp  = temp;
      row.known = 1'b1;
      row.duty  = duty;
      row.below = below;
      return row;
   endfunction

   // ---------------------------------------------------------------------------
   // driving tasks, all driven just after the rising edge
   // ---------------------------------------------------------------------------

   // offer one sample and hold it until the unit takes it
   task automatic send_temp(input logic signed [fci_pkg::TEMP_W-1:0] temp,
                            input duty_beat_type expected);
      req_temperature <= temp;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pending_duty.push_back(expected);
      beats_sent++;
   endtask

   // sender gap with start low, n at least one
   task automatic idle(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // drop start and wait for every outstanding beat to come back
   task automatic settle();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_duty.size() != 0);
   endtask

   // one write beat; the caller drops csr_we after the last one of a burst
   task automatic write_csr(input logic [fci_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fci_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      apply_csr(idx, value);
   endtask

   // program a fresh curve; the first two phases use the register extremes
   task automatic load_random_curve(input int phase);
      logic [fci_pkg::CSR_W-1:0]   word [NUM_POINTS];
      logic [fci_pkg::COUNT_W-1:0] count;
      int                          deg;
      int                          pct;
      int                          k;
      if (phase == 0) begin
         count = 3'd7;
         for (k = 0; k < NUM_POINTS; k++) begin
            word[k] = 16'hFFFF;
         end
      end else if (phase == 1) begin
         count = 3'd0;
         for (k = 0; k < NUM_POINTS; k++) begin
            word[k] = 16'h0000;
         end
      end else if ($urandom_range(0, 4) == 0) begin
         // raw register noise, points in no particular order
         count = fci_pkg::COUNT_W'($urandom);
         for (k = 0; k < NUM_POINTS; k++) begin
            word[k] = fci_pkg::CSR_W'($urandom);
         end
      end else begin
         // well-formed ascending curve, sometimes with repeated temperatures
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  count = 3'd0;
               end
               1: begin
                  count = 3'd1;
               end
               default: begin
                  count = 3'd7;
               end
            endcase
         end else begin
            count = fci_pkg::COUNT_W'($urandom_range(2, NUM_POINTS));
         end
         deg = int'($urandom_range(0, 100)) - 128;
         for (k = 0; k < NUM_POINTS; k++) begin
            if (deg > 127) begin
               deg = 127;
            end
            pct = ($urandom_range(0, 9) == 0) ? 255 : int'($urandom_range(0, 100));
            word[k] = {deg[7:0], pct[7:0]};
            deg = deg + int'($urandom_range(0, 60));
         end
      end
      settle();
      if ($urandom_range(0, 2) == 0) begin
         write_csr(CSR_UNMAPPED, fci_pkg::CSR_W'($urandom));
      end
      write_csr(fci_pkg::CSR_POINT_COUNT, fci_pkg::CSR_W'(count));
      for (k = 0; k < NUM_POINTS; k++) begin
         write_csr(fci_pkg::CSR_POINT_0 + fci_pkg::CSR_IDX_W'(k), word[k]);
      end
      csr_we <= 1'b0;
      curves_loaded++;
   endtask

   // sample: full range noise, near a curve point, or on or next to one
   function automatic logic signed [fci_pkg::TEMP_W-1:0] pick_temp();
      int mode;
      int k;
      int base;
      mode = $urandom_range(0, 9);
      k    = $urandom_range(0, NUM_POINTS - 1);
      base = int'($signed(cfg_point[k][15:8])) * 256;
      if (mode < 3) begin
         return fci_pkg::TEMP_W'($urandom);
      end else if (mode < 8) begin
         return fci_pkg::TEMP_W'(base + int'($urandom_range(0, 8191)) - 4096);
      end
      return fci_pkg::TEMP_W'(base + int'($urandom_range(0, 2)) - 1);
   endfunction

   // ---------------------------------------------------------------------------
   // response checker: every strobe is a beat, matched in order
   // ---------------------------------------------------------------------------

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   always @(posedge clock) begin
      duty_beat_type expected;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_below_curve) begin
            below_seen++;
         end
         if (rsp_duty == fci_pkg::DUTY_MAX) begin
            full_seen++;
         end
         if (pending_duty.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat duty %0d below %0b",
                                    rsp_duty, rsp_below_curve));
         end else begin
            expected = pending_duty.pop_front();
            if (rsp_duty !== expected.duty) begin
               flag_mismatch($sformatf("beat %0d duty expected %0d got %0d",
                                       results_seen, expected.duty, rsp_duty));
            end
            if (rsp_below_curve !== expected.below) begin
               flag_mismatch($sformatf("beat %0d below_curve expected %0b got %0b",
                                       results_seen, expected.below,
                                       rsp_below_curve));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   initial begin
      int                                r;
      int                                phase;
      int                                n;
      logic signed [fci_pkg::TEMP_W-1:0] temp;
      duty_beat_type                     expected;

      reset           = 1'b1;
      start           = 1'b0;
      req_temperature = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      beats_sent      = 0;
      results_seen    = 0;
      below_seen      = 0;
      full_seen       = 0;
      curves_loaded   = 1;
      mismatches      = 0;

      // register reset values: the default 30 to 70 degree ramp
      cfg_count = fci_pkg::COUNT_RESET;
      for (r = 0; r < NUM_POINTS; r++) begin
         cfg_point[r] = '0;
      end
      cfg_point[0] = fci_pkg::POINT_0_RESET;
      cfg_point[1] = fci_pkg::POINT_1_RESET;

      plan = '{
         // default curve straight out of reset
         known_row(16'sh8000, 15'd0, 1'b1),              // most negative sample
         known_row(-16'sd1, 15'd0, 1'b1),                // minus one lsb
         known_row(16'sd7679, 15'd0, 1'b1),              // just under the first point
         known_row(16'sd7680, 15'd0, 1'b0),              // on the first point
         sample_row(16'sd12800),                         // mid ramp
         sample_row(16'sd17919),                         // just under the last point
         known_row(16'sd17920, fci_pkg::DUTY_MAX, 1'b0), // on the last point
         known_row(16'sh7FFF, fci_pkg::DUTY_MAX, 1'b0),  // most positive sample
         // full six-point curve: coldest point, capped duty byte, falling segment
         csr_row(fci_pkg::CSR_POINT_COUNT, 16'd6),
         csr_row(fci_pkg::CSR_POINT_0, 16'h8000),
         csr_row(fci_pkg::CSR_POINT_0 + 3'd1, 16'hECFF),
         csr_row(fci_pkg::CSR_POINT_0 + 3'd2, 16'h0028),
         csr_row(fci_pkg::CSR_POINT_0 + 3'd3, 16'h190A),
         csr_row(fci_pkg::CSR_POINT_0 + 3'd4, 16'h3C50),
         csr_row(fci_pkg::CSR_POINT_0 + 3'd5, 16'h7F64),
         sample_row(16'sh8000),
         sample_row(-16'sd5000),
         sample_row(16'sd100),
         sample_row(16'sd4000),
         known_row(16'sd32512, fci_pkg::DUTY_MAX, 1'b0),
         known_row(16'sh7FFF, fci_pkg::DUTY_MAX, 1'b0),
         // count under range falls back to two points
         csr_row(fci_pkg::CSR_POINT_COUNT, 16'd0),
         known_row(16'sh7FFF, fci_pkg::DUTY_MAX, 1'b0),
         sample_row(16'sh8000),
         // count over range is held at the maximum
         csr_row(fci_pkg::CSR_POINT_COUNT, 16'd7),
         known_row(16'sh7FFF, fci_pkg::DUTY_MAX, 1'b0),
         // points out of order
         csr_row(fci_pkg::CSR_POINT_COUNT, 16'd3),
         csr_row(fci_pkg::CSR_POINT_0, 16'h0A14),
         csr_row(fci_pkg::CSR_POINT_0 + 3'd1, 16'h325A),
         csr_row(fci_pkg::CSR_POINT_0 + 3'd2, 16'h141E),
         sample_row(16'sd15360),
         sample_row(16'sd10240),
         // write to an unmapped index changes nothing
         csr_row(CSR_UNMAPPED, 16'hFFFF),
         sample_row(16'sd12800)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      for (r = 0; r < PLAN_LEN; r++) begin
         if (plan[r].is_csr) begin
            if (r == 0 || !plan[r - 1].is_csr) begin
               settle();
            end
            write_csr(plan[r].idx, plan[r].wdata);
            if (r == PLAN_LEN - 1 || !plan[r + 1].is_csr) begin
               csr_we <= 1'b0;
               curves_loaded++;
            end
         end else begin
            if ($urandom_range(0, 99) < 31) begin
               idle($urandom_range(1, 40));
            end
            if (plan[r].known) begin
               expected.duty  = plan[r].duty;
               expected.below = plan[r].below;
            end else begin
               expected = curve_duty(plan[r].temp);
            end
            send_temp(plan[r].temp, expected);
         end
      end

      // random part: one curve per phase, phases 4 and 5 run back to back
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         load_random_curve(phase);
         for (n = 0; n < BEATS_PER_PHASE; n++) begin
            if (phase == 7 && n == BEATS_PER_PHASE / 2) begin
               // hold off until the unit has answered everything
               settle();
            end else if (phase != 4 && phase != 5 && $urandom_range(0, 99) < 31) begin
               idle($urandom_range(1, 40));
            end
            temp = pick_temp();
            send_temp(temp, curve_duty(temp));
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (pending_duty.size() != 0) begin
         flag_mismatch($sformatf("%0d beats never answered", pending_duty.size()));
      end
      $display("run covered %0d sample beats over %0d curve settings, %0d results checked",
               beats_sent, curves_loaded, results_seen);
      $display("%0d results below the curve, %0d at full duty", below_seen, full_seen);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
